FILE: rtl/ouart_pkg.sv
`default_nettype none
package ouart_pkg;

  // frame format
  localparam int DATA_BITS          = 8;
  localparam int TICKS_PER_BIT      = 3;
  localparam int FIRST_SAMPLE_TICKS = 4;

  // counter and byte widths
  localparam int TICK_W = 5;
  localparam int BITS_W = 4;
  localparam int BYTE_W = 8;

  // receiver phases
  localparam logic [1:0] PH_OFF  = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  // one result per tick
  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_value;
  } rx_result_t;

endpackage
`default_nettype wire

FILE: rtl/ouart_core.sv
`default_nettype none
module ouart_core
  import ouart_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       rx_line,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  output rx_result_t      result
);

  logic [1:0]           rx_phase;
  logic [1:0]           rx_phase_next;
  logic [TICK_W-1:0]    tick_countdown;
  logic [TICK_W-1:0]    tick_countdown_next;
  logic [BITS_W-1:0]    bits_left;
  logic [BITS_W-1:0]    bits_left_next;
  logic [DATA_BITS-1:0] shift_reg;
  logic [DATA_BITS-1:0] shift_reg_next;
  logic [TICK_W-1:0]    tick_dec;
  logic [BITS_W-1:0]    bits_dec;
  logic                 tick_expired;

  // down-counters wrap as plain counters do
  assign tick_dec     = tick_countdown - TICK_W'(1);
  assign bits_dec     = bits_left - BITS_W'(1);
  assign tick_expired = (tick_dec == '0);

  // per-tick state update and result
  always_comb begin
    rx_phase_next       = rx_phase;
    tick_countdown_next = tick_countdown;
    bits_left_next      = bits_left;
    shift_reg_next      = shift_reg;
    result.byte_valid   = 1'b0;
    result.byte_value   = '0;
    if (cfg_we) begin
      // enable write: disable aborts, enable starts hunting from off
      if (!cfg_wdata) begin
        rx_phase_next = PH_OFF;
      end else if (rx_phase == PH_OFF) begin
        rx_phase_next = PH_HUNT;
      end
    end else if (step) begin
      unique case (rx_phase)
        PH_HUNT: begin
          if (!rx_line) begin
            tick_countdown_next = TICK_W'(FIRST_SAMPLE_TICKS);
            bits_left_next      = BITS_W'(DATA_BITS);
            rx_phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          tick_countdown_next = tick_dec;
          if (tick_expired) begin
            tick_countdown_next = TICK_W'(TICKS_PER_BIT);
            shift_reg_next      = {rx_line, shift_reg[DATA_BITS-1:1]};
            bits_left_next      = bits_dec;
            if (bits_dec == '0) begin
              rx_phase_next = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          tick_countdown_next = tick_dec;
          if (tick_expired) begin
            tick_countdown_next = TICK_W'(TICKS_PER_BIT);
            // low stop bit just rechecks one bit time later
            if (rx_line) begin
              rx_phase_next     = PH_HUNT;
              result.byte_valid = 1'b1;
              result.byte_value = BYTE_W'(shift_reg);
            end
          end
        end
        default: begin
          // disabled: line ignored
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase       <= PH_OFF;
      tick_countdown <= '0;
      bits_left      <= '0;
      shift_reg      <= '0;
    end else begin
      rx_phase       <= rx_phase_next;
      tick_countdown <= tick_countdown_next;
      bits_left      <= bits_left_next;
      shift_reg      <= shift_reg_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ouart_out_reg.sv
`default_nettype none
module ouart_out_reg
  import ouart_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   step,
  input  wire rx_result_t        result,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   byte_valid,
  output logic [BYTE_W-1:0]      byte_value
);

  rx_result_t held;

  // take a new request whenever the result slot is free or draining
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held <= result;
    end
  end

  assign byte_valid = held.byte_valid;
  assign byte_value = held.byte_value;

endmodule
`default_nettype wire

FILE: rtl/oversampled_uart_receiver_unit.sv
`default_nettype none
// Oversampled UART receiver, 8 data bits, one stop bit, LSB first.
// Input channel: one request per oversampling tick (in_valid/in_ready),
//   carrying rx_line, the sampled line level for that tick.
// Output channel: exactly one result per request (out_valid/out_ready):
//   byte_valid is 1 on the tick that completes a frame, with the byte in
//   byte_value; otherwise byte_valid and byte_value are 0.
// Configuration: cfg_we writes cfg_wdata as the receiver enable, held in the phase.
//   Enabling starts the hunt for a start bit from off; disabling aborts any frame.
// Timing: the result of a request is on the output in the cycle after it is
//   accepted. Throughput: one request per cycle while out_ready allows, with a
//   combinational phase and counter update before the result register.
// Reset: the receiver is disabled, counters and shift register are cleared,
//   and the result register is empty.
// Stall: when the result waits and out_ready is low, in_ready drops and
//   the result holds; in_ready returns the cycle the result is taken.
module oversampled_uart_receiver_unit
  import ouart_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              rx_line,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   byte_valid,
  output logic [BYTE_W-1:0]      byte_value
);

  rx_result_t result;
  logic       step;

  // frame decoder and receiver state
  ouart_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_line   (rx_line),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  // result register and handshake
  ouart_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .step       (step),
    .result     (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_valid (byte_valid),
    .byte_value (byte_value)
  );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
  import ouart_pkg::*;

  localparam int DATA_END = TICKS_PER_BIT * (DATA_BITS + 1);
  localparam int FULL     = 1000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              rx_line = 1'b1;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_value;

  // line samples waiting to go out, and predicted per-tick results
  logic       pending_ticks[$];
  rx_result_t expected_rx[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;

  // receiver state as predicted
  logic [1:0]           rx_phase_m;
  logic [TICK_W-1:0]    tick_m;
  logic [BITS_W-1:0]    bits_m;
  logic [DATA_BITS-1:0] shift_m;

  oversampled_uart_receiver_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_line   (rx_line),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_valid(byte_valid),
    .byte_value(byte_value)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the receiver by one tick and return what it should report
  function automatic rx_result_t next_rx_result(input logic line);
    rx_result_t r;
    r = '0;
    case (rx_phase_m)
      PH_HUNT: begin
        if (!line) begin
          tick_m     = TICK_W'(FIRST_SAMPLE_TICKS);
          bits_m     = BITS_W'(DATA_BITS);
          rx_phase_m = PH_DATA;
        end
      end
      PH_DATA: begin
        tick_m = tick_m - 1'b1;
        if (tick_m == '0) begin
          tick_m  = TICK_W'(TICKS_PER_BIT);
          shift_m = {line, shift_m[DATA_BITS-1:1]};
          bits_m  = bits_m - 1'b1;
          if (bits_m == '0) rx_phase_m = PH_STOP;
        end
      end
      PH_STOP: begin
        tick_m = tick_m - 1'b1;
        if (tick_m == '0) begin
          tick_m = TICK_W'(TICKS_PER_BIT);
          if (line) begin
            rx_phase_m   = PH_HUNT;
            r.byte_valid = 1'b1;
            r.byte_value = shift_m[BYTE_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
    mismatches++;
  endtask

  // queue the ticks [first, last) of one frame, flipping samples at random if asked
  task automatic push_frame(input logic [DATA_BITS-1:0] b, input int low_stops,
                            input int tail, input int flip_pct, input int first,
                            input int last);
    int   len;
    logic lvl;
    len = DATA_END + TICKS_PER_BIT * (low_stops + 1) + tail;
    for (int i = 0; i < len; i++) begin
      if (i < TICKS_PER_BIT) lvl = 1'b0;
      else if (i < DATA_END) lvl = b[(i - TICKS_PER_BIT) / TICKS_PER_BIT];
      else if (i < DATA_END + TICKS_PER_BIT * low_stops) lvl = 1'b0;
      else lvl = 1'b1;
      if ($urandom_range(0, 99) < flip_pct) lvl = ~lvl;
      if (i >= first && i < last) pending_ticks.push_back(lvl);
    end
  endtask

  task automatic push_noise(input int n);
    repeat (n) pending_ticks.push_back(1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_rx.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_enable(input logic en);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // driver: one line sample per request, with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_valid <= 1'b1;
        rx_line  <= pending_ticks.pop_front();
        if ($urandom_range(0, 99) < send_idle_pct) gap_left = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check results, track enable writes, predict accepted ticks
  always @(posedge clk) begin : mon
    rx_result_t want;
    if (rst) begin
      rx_phase_m = PH_OFF;
      tick_m     = '0;
      bits_m     = '0;
      shift_m    = '0;
      expected_rx.delete();
      stall_left = 0;
      out_ready <= 1'b0;
    end else begin
      // compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_rx.size() == 0) begin
          report_mismatch("unexpected result", byte_value, 0);
        end else begin
          want = expected_rx.pop_front();
          if (byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", byte_valid, want.byte_valid);
          if (byte_value !== want.byte_value)
            report_mismatch("byte_value", byte_value, want.byte_value);
        end
      end
      // enable write: disabling aborts a frame, enabling starts a hunt only from off
      if (cfg_we) begin
        if (!cfg_wdata) rx_phase_m = PH_OFF;
        else if (rx_phase_m == PH_OFF) rx_phase_m = PH_HUNT;
      end
      if (in_valid && in_ready) expected_rx.push_back(next_rx_result(rx_line));
      // random stall bursts on the result side
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < recv_stall_pct) stall_left = $urandom_range(1, 15);
      end
    end
  end

  // stimulus
  initial begin
    int sel;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct  = 25;
    recv_stall_pct = 25;

    // disabled receiver ignores the line
    write_enable(1'b0);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    wait_idle();

    // all-zero byte with a low stop bit, then all-ones back to back
    write_enable(1'b1);
    push_frame(8'h00, 1, 2, 0, 0, FULL);
    push_frame(8'hFF, 0, 0, 0, 0, FULL);
    wait_idle();

    // stop mid frame until drained, re-enable while busy (no effect), finish
    push_frame(8'h3C, 0, 2, 0, 0, 15);
    wait_idle();
    write_enable(1'b1);
    push_frame(8'h3C, 0, 2, 0, 15, FULL);
    wait_idle();

    // disable mid frame aborts it, then a fresh frame after re-enable
    push_frame(8'hC3, 0, 0, 0, 0, 12);
    wait_idle();
    write_enable(1'b0);
    push_noise(4);
    wait_idle();
    write_enable(1'b1);
    push_frame(8'h81, 0, 3, 0, 0, FULL);
    wait_idle();

    // random frames, glitches, noise and cut-off frames
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
        1: begin
          send_idle_pct  = 0;
          recv_stall_pct = 35;
        end
        2: begin
          send_idle_pct  = 35;
          recv_stall_pct = 0;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (ph == 2) begin
        write_enable(1'b0);
        push_noise(10);
        wait_idle();
      end
      write_enable(1'b1);
      repeat (3) begin
        sel = $urandom_range(0, 9);
        if (sel < 6)
          push_frame(8'($urandom_range(0, 255)), (sel == 0) ? $urandom_range(1, 3) : 0,
                     $urandom_range(0, 4), 0, 0, FULL);
        else if (sel < 8)
          push_frame(8'($urandom_range(0, 255)), $urandom_range(0, 1),
                     $urandom_range(0, 4), 5, 0, FULL);
        else if (sel == 8)
          push_noise($urandom_range(1, 12));
        else
          push_frame(8'($urandom_range(0, 255)), 0, 0, 0, 0, $urandom_range(1, 29));
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (expected_rx.size() != 0)
      report_mismatch("results never delivered", 0, expected_rx.size());
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
